>>> design/hsvrgb_pkg.sv
// Shared types and constants for the full-value HSV to RGB converter.
// No dependencies; used by hsv_to_rgb_full_value.
package hsvrgb_pkg;

	localparam int unsigned HUE_W   = 9;
	localparam int unsigned SAT_W   = 7;
	localparam int unsigned LEVEL_W = 8;

	// Channel numerator range is 0..6000 over the common denominator 6000
	localparam int unsigned NUMER_W = 13;
	localparam logic [NUMER_W-1:0] NUMER_FULL = 13'd6000;

	localparam logic [HUE_W-1:0]   HUE_WRAP = 9'd360;
	localparam logic [SAT_W-1:0]   SAT_MAX  = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

	// level = floor((51*L + 600) / 1200) = floor(floor((51*L + 600) / 16) / 75)
	// floor(y / 75) = (y * 27963) >> 21, exact for y < 28727
	localparam int unsigned SCALED_W = 19;
	localparam int unsigned QUOT_W   = 15;
	localparam int unsigned RECIP_W  = 15;
	localparam int unsigned RECIP_SH = 21;
	localparam logic [RECIP_W-1:0] RECIP_75 = 15'd27963;

	typedef struct packed {
		logic [HUE_W-1:0] hue_degrees;
		logic [SAT_W-1:0] saturation_percent;
	} hsv_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
	} rgb_t;

endpackage

>>> design/hsv_to_rgb_full_value.sv
// Each accepted hsv transfer is registered through stages s1, s2, s3 and s4;
// rgb_valid is the s4 valid bit. Throughput: one transfer per cycle while
// rgb_ready is high; each of the four register stages advances when it is
// empty or its successor frees up, so bubbles collapse under stall.
// Reset: arst_n clears all stage valid bits asynchronously; the pipeline comes
// out of reset empty and ready. Data registers are not reset. Depends on hsvrgb_pkg.
module hsv_to_rgb_full_value (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hsv_valid,
	output logic              hsv_ready,
	input  hsvrgb_pkg::hsv_t  hsv,
	output logic              rgb_valid,
	input  logic              rgb_ready,
	output hsvrgb_pkg::rgb_t  rgb
);

	// Hue sector: which channel is full, which ramps, which sits at the floor
	typedef enum logic [2:0] {
		SEC_RED_GRN  = 3'd0,  // R full, G ramp, B floor
		SEC_GRN_RED  = 3'd1,  // G full, R ramp, B floor
		SEC_GRN_BLU  = 3'd2,  // G full, B ramp, R floor
		SEC_BLU_GRN  = 3'd3,  // B full, G ramp, R floor
		SEC_BLU_RED  = 3'd4,  // B full, R ramp, G floor
		SEC_RED_BLU  = 3'd5   // R full, B ramp, G floor
	} sector_t;

	// ---------------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its data moves on.
	// ---------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4    = !valid_s4 || rgb_ready;
	assign adv_s3    = !valid_s3 || adv_s4;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign hsv_ready = adv_s1;
	assign rgb_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= hsv_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: wrap hue, clamp saturation, find sector and the distance
	// d = |(hue mod 120) - 60| from the sector-pair midpoint.
	// ---------------------------------------------------------------------
	logic [hsvrgb_pkg::HUE_W-1:0] hue_wrap;
	logic [hsvrgb_pkg::HUE_W-1:0] hue_m120;
	logic [hsvrgb_pkg::SAT_W-1:0] sat_clamp;
	logic [5:0]                   hue_dist;
	sector_t                      sector;

	always_comb begin
		hue_wrap = (hsv.hue_degrees >= hsvrgb_pkg::HUE_WRAP)
			? hsv.hue_degrees - hsvrgb_pkg::HUE_WRAP : hsv.hue_degrees;
		sat_clamp = (hsv.saturation_percent > hsvrgb_pkg::SAT_MAX)
			? hsvrgb_pkg::SAT_MAX : hsv.saturation_percent;

		if (hue_wrap < 9'd60)       sector = SEC_RED_GRN;
		else if (hue_wrap < 9'd120) sector = SEC_GRN_RED;
		else if (hue_wrap < 9'd180) sector = SEC_GRN_BLU;
		else if (hue_wrap < 9'd240) sector = SEC_BLU_GRN;
		else if (hue_wrap < 9'd300) sector = SEC_BLU_RED;
		else                        sector = SEC_RED_BLU;

		if (hue_wrap >= 9'd240)      hue_m120 = hue_wrap - 9'd240;
		else if (hue_wrap >= 9'd120) hue_m120 = hue_wrap - 9'd120;
		else                         hue_m120 = hue_wrap;

		hue_dist = (hue_m120 >= 9'd60) ? 6'(hue_m120 - 9'd60) : 6'(9'd60 - hue_m120);
	end

	sector_t                      sector_s1;
	logic [hsvrgb_pkg::SAT_W-1:0] sat_s1;
	logic [5:0]                   hue_dist_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && hsv_valid) begin
			sector_s1   <= sector;
			sat_s1      <= sat_clamp;
			hue_dist_s1 <= hue_dist;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: channel numerators over 6000 for the ramp and floor channels.
	// ---------------------------------------------------------------------
	logic [hsvrgb_pkg::NUMER_W-1:0] ramp_prod;
	logic [hsvrgb_pkg::NUMER_W-1:0] low_prod;

	assign ramp_prod = hsvrgb_pkg::NUMER_W'(sat_s1) * hsvrgb_pkg::NUMER_W'(hue_dist_s1);
	assign low_prod  = hsvrgb_pkg::NUMER_W'(sat_s1) * 13'd60;

	sector_t                        sector_s2;
	logic [hsvrgb_pkg::NUMER_W-1:0] ramp_s2;
	logic [hsvrgb_pkg::NUMER_W-1:0] low_s2;

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			sector_s2 <= sector_s1;
			ramp_s2   <= hsvrgb_pkg::NUMER_FULL - ramp_prod;
			low_s2    <= hsvrgb_pkg::NUMER_FULL - low_prod;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: scale by 51 and add the half-up bias, then drop the power-of-two
	// part (16) of the 1200 divisor.
	// ---------------------------------------------------------------------
	logic [hsvrgb_pkg::SCALED_W-1:0] ramp_scaled;
	logic [hsvrgb_pkg::SCALED_W-1:0] low_scaled;

	assign ramp_scaled = hsvrgb_pkg::SCALED_W'(ramp_s2) * 19'd51 + 19'd600;
	assign low_scaled  = hsvrgb_pkg::SCALED_W'(low_s2) * 19'd51 + 19'd600;

	sector_t                       sector_s3;
	logic [hsvrgb_pkg::QUOT_W-1:0] ramp_s3;
	logic [hsvrgb_pkg::QUOT_W-1:0] low_s3;

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			sector_s3 <= sector_s2;
			ramp_s3   <= ramp_scaled[hsvrgb_pkg::SCALED_W-1:4];
			low_s3    <= low_scaled[hsvrgb_pkg::SCALED_W-1:4];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: divide by 75 through the reciprocal, then route the three
	// levels to red, green and blue by sector.
	// ---------------------------------------------------------------------
	localparam int unsigned PROD_W = hsvrgb_pkg::QUOT_W + hsvrgb_pkg::RECIP_W;
	localparam int unsigned LVL_LO = hsvrgb_pkg::RECIP_SH;
	localparam int unsigned LVL_HI = hsvrgb_pkg::RECIP_SH + hsvrgb_pkg::LEVEL_W - 1;

	logic [PROD_W-1:0]              ramp_mul;
	logic [PROD_W-1:0]              low_mul;
	logic [hsvrgb_pkg::LEVEL_W-1:0] ramp_lvl;
	logic [hsvrgb_pkg::LEVEL_W-1:0] low_lvl;
	hsvrgb_pkg::rgb_t               rgb_next;

	assign ramp_mul = PROD_W'(ramp_s3) * PROD_W'(hsvrgb_pkg::RECIP_75);
	assign low_mul  = PROD_W'(low_s3) * PROD_W'(hsvrgb_pkg::RECIP_75);
	assign ramp_lvl = ramp_mul[LVL_HI:LVL_LO];
	assign low_lvl  = low_mul[LVL_HI:LVL_LO];

	always_comb begin
		case (sector_s3)
			SEC_RED_GRN: begin
				rgb_next = '{hsvrgb_pkg::LEVEL_FULL, ramp_lvl, low_lvl};
			end
			SEC_GRN_RED: begin
				rgb_next = '{ramp_lvl, hsvrgb_pkg::LEVEL_FULL, low_lvl};
			end
			SEC_GRN_BLU: begin
				rgb_next = '{low_lvl, hsvrgb_pkg::LEVEL_FULL, ramp_lvl};
			end
			SEC_BLU_GRN: begin
				rgb_next = '{low_lvl, ramp_lvl, hsvrgb_pkg::LEVEL_FULL};
			end
			SEC_BLU_RED: begin
				rgb_next = '{ramp_lvl, low_lvl, hsvrgb_pkg::LEVEL_FULL};
			end
			default: begin
				rgb_next = '{hsvrgb_pkg::LEVEL_FULL, low_lvl, ramp_lvl};
			end
		endcase
	end

	// Hold the result while the consumer stalls
	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			rgb <= rgb_next;
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for hsv_to_rgb_full_value: a directed table, then random hue/saturation
// transfers, each checked against a known value or an integer HSV to RGB predictor.
// Depends on hsvrgb_pkg and the hsv_to_rgb_full_value RTL.
module tb_top;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 900;
	localparam int LATENCY      = 4;
	localparam int CYCLE_LIMIT  = 200000;
	// receiver hold-off: length in cycles, and the result count that triggers it
	localparam int LONG_HOLD    = 160;
	localparam int HOLD_AFTER   = 350;

	// Hue sector names: full channel first, then the ramping one
	typedef enum int {
		SEC_RG, SEC_GR, SEC_GB, SEC_BG, SEC_BR, SEC_RB
	} sector_e;

	// One directed row; want is used only when known is set, otherwise predict
	typedef struct packed {
		logic [hsvrgb_pkg::HUE_W-1:0] hue;
		logic [hsvrgb_pkg::SAT_W-1:0] sat;
		logic                         known;
		hsvrgb_pkg::rgb_t             want;
	} dir_row_t;

	// What a result is checked against, with its cause for the log
	typedef struct {
		hsvrgb_pkg::hsv_t cause;
		hsvrgb_pkg::rgb_t want;
	} rgb_expect_t;

	localparam int N_DIRECTED = 22;
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		{9'd0,   7'd0,   1'b1, 8'd255, 8'd255, 8'd255},	// zero saturation: white
		{9'd0,   7'd100, 1'b1, 8'd255, 8'd0,   8'd0},	// pure red
		{9'd60,  7'd100, 1'b1, 8'd255, 8'd255, 8'd0},	// yellow
		{9'd120, 7'd100, 1'b1, 8'd0,   8'd255, 8'd0},	// pure green
		{9'd180, 7'd100, 1'b1, 8'd0,   8'd255, 8'd255},	// cyan
		{9'd240, 7'd100, 1'b1, 8'd0,   8'd0,   8'd255},	// pure blue
		{9'd300, 7'd100, 1'b1, 8'd255, 8'd0,   8'd255},	// magenta
		{9'd360, 7'd100, 1'b1, 8'd255, 8'd0,   8'd0},	// 360 wraps to red
		{9'd0,   7'd127, 1'b1, 8'd255, 8'd0,   8'd0},	// saturation clamps to 100
		{9'd0,   7'd50,  1'b1, 8'd255, 8'd128, 8'd128},	// 127.5 rounds up
		{9'd256, 7'd0,   1'b1, 8'd255, 8'd255, 8'd255},	// white off the primaries
		{9'd359, 7'd100, 1'b0, 24'd0},
		{9'd59,  7'd1,   1'b0, 24'd0},
		{9'd61,  7'd99,  1'b0, 24'd0},
		{9'd119, 7'd37,  1'b0, 24'd0},
		{9'd239, 7'd73,  1'b0, 24'd0},
		{9'd299, 7'd88,  1'b0, 24'd0},
		{9'd361, 7'd64,  1'b0, 24'd0},	// wrap into sector 0
		{9'd419, 7'd101, 1'b0, 24'd0},	// wrap and clamp together
		{9'd511, 7'd127, 1'b0, 24'd0},	// all ones
		{9'd170, 7'd85,  1'b0, 24'd0},
		{9'd1,   7'd1,   1'b0, 24'd0}
	};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             hsv_valid = 1'b0;
	logic             hsv_ready;
	hsvrgb_pkg::hsv_t hsv       = '0;
	logic             rgb_valid;
	logic             rgb_ready = 1'b0;
	hsvrgb_pkg::rgb_t rgb;

	rgb_expect_t pending_rgb[$];
	int          errors = 0;
	int          n_sent = 0;
	int          n_checked = 0;
	int          n_wrapped = 0;
	int          n_clamped = 0;
	int          n_white = 0;
	int          burst_left = 0;
	bit          long_hold_done = 1'b0;

	hsv_to_rgb_full_value dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Scale a numerator over 6000 to an 8-bit level, rounding half up
	function automatic logic [hsvrgb_pkg::LEVEL_W-1:0] round_level(input int unsigned numer);
		int unsigned q;
		q = (255 * numer + 32'(hsvrgb_pkg::NUMER_FULL) / 2) / 32'(hsvrgb_pkg::NUMER_FULL);
		return q[hsvrgb_pkg::LEVEL_W-1:0];
	endfunction

	// Integer HSV to RGB with value at full: wrap hue once, clamp saturation,
	// then place full, ramp and floor levels by sector
	function automatic hsvrgb_pkg::rgb_t predict_rgb(input hsvrgb_pkg::hsv_t x);
		int unsigned hue, sat, m120, hue_dist, full_n;
		logic [hsvrgb_pkg::LEVEL_W-1:0] full_l, ramp_l, floor_l;
		hsvrgb_pkg::rgb_t y;
		hue    = 32'(x.hue_degrees);
		sat    = 32'(x.saturation_percent);
		full_n = 32'(hsvrgb_pkg::NUMER_FULL);
		if (hue >= 32'(hsvrgb_pkg::HUE_WRAP))
			hue -= 32'(hsvrgb_pkg::HUE_WRAP);
		if (sat > 32'(hsvrgb_pkg::SAT_MAX))
			sat = 32'(hsvrgb_pkg::SAT_MAX);
		m120 = hue % 120;
		hue_dist = (m120 >= 60) ? m120 - 60 : 60 - m120;
		full_l  = round_level(full_n);
		ramp_l  = round_level(full_n - sat * hue_dist);
		floor_l = round_level(full_n - 60 * sat);
		case (sector_e'(hue / 60))
			SEC_RG:  y = {full_l, ramp_l, floor_l};
			SEC_GR:  y = {ramp_l, full_l, floor_l};
			SEC_GB:  y = {floor_l, full_l, ramp_l};
			SEC_BG:  y = {floor_l, ramp_l, full_l};
			SEC_BR:  y = {ramp_l, floor_l, full_l};
			default: y = {full_l, floor_l, ramp_l};
		endcase
		return y;
	endfunction

	// Mostly legal pairs, with wrapped hues, clamped saturations, raw bit
	// patterns and sector edges mixed in
	function automatic hsvrgb_pkg::hsv_t random_hsv();
		hsvrgb_pkg::hsv_t x;
		x.hue_degrees        = hsvrgb_pkg::HUE_W'($urandom_range(0, hsvrgb_pkg::HUE_WRAP));
		x.saturation_percent = hsvrgb_pkg::SAT_W'($urandom_range(0, hsvrgb_pkg::SAT_MAX));
		case ($urandom_range(0, 9))
			0: x.hue_degrees =
				hsvrgb_pkg::HUE_W'($urandom_range(hsvrgb_pkg::HUE_WRAP + 1, 511));
			1: x.saturation_percent =
				hsvrgb_pkg::SAT_W'($urandom_range(hsvrgb_pkg::SAT_MAX + 1, 127));
			2: begin
				x.hue_degrees        = hsvrgb_pkg::HUE_W'($urandom);
				x.saturation_percent = hsvrgb_pkg::SAT_W'($urandom);
			end
			3: x.hue_degrees =
				hsvrgb_pkg::HUE_W'(60 * $urandom_range(1, 6) - 1 + $urandom_range(0, 2));
			4: x.saturation_percent = hsvrgb_pkg::SAT_W'(($urandom_range(0, 1) == 0) ?
				$urandom_range(0, 1) :
				$urandom_range(hsvrgb_pkg::SAT_MAX - 1, hsvrgb_pkg::SAT_MAX));
			default: ;
		endcase
		return x;
	endfunction

	// Offer one transfer and hold it until the block takes it
	task automatic offer(input hsvrgb_pkg::hsv_t x, input hsvrgb_pkg::rgb_t want);
		hsv       <= x;
		hsv_valid <= 1'b1;
		do @(posedge clk); while (!hsv_ready);
		pending_rgb.push_back('{cause: x, want: want});
		n_sent++;
		if (x.hue_degrees >= hsvrgb_pkg::HUE_WRAP)
			n_wrapped++;
		if (x.saturation_percent > hsvrgb_pkg::SAT_MAX)
			n_clamped++;
		if (x.saturation_percent == 0)
			n_white++;
	endtask

	// Advance the burst; at its end drop valid for a random gap and pick
	// the next burst length, now and then a long one with no idling
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			hsv_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
				: $urandom_range(0, 24);
		end
	endtask

	// Drop valid and hold off until every expected result has come back
	task automatic drain_results();
		hsv_valid <= 1'b0;
		do @(posedge clk); while (pending_rgb.size() != 0);
	endtask

	task automatic check_level(input string chan, input hsvrgb_pkg::hsv_t cause,
			input logic [hsvrgb_pkg::LEVEL_W-1:0] want,
			input logic [hsvrgb_pkg::LEVEL_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s for hue %0d sat %0d: expected %0d, actual %0d",
				$time, chan, cause.hue_degrees, cause.saturation_percent, want, got);
		end
	endtask

	// Compare each rgb transfer against the oldest expectation
	always @(posedge clk) begin : compare_rgb
		rgb_expect_t head;
		if (arst_n && rgb_valid && rgb_ready) begin
			if (pending_rgb.size() == 0) begin
				errors++;
				$display("%0t: unexpected rgb transfer, expected none, actual %0d/%0d/%0d",
					$time, rgb.red_level, rgb.green_level, rgb.blue_level);
			end else begin
				head = pending_rgb.pop_front();
				check_level("red",   head.cause, head.want.red_level,   rgb.red_level);
				check_level("green", head.cause, head.want.green_level, rgb.green_level);
				check_level("blue",  head.cause, head.want.blue_level,  rgb.blue_level);
				n_checked++;
			end
		end
	end

	// Receiver: stall in segments of random mode and length; once, after
	// enough results, hold ready low for a long stretch so the block fills
	initial begin : receiver
		int mode, seg, k;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && n_checked >= HOLD_AFTER) begin
				rgb_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(10, 80);
			for (k = 0; k < seg; k++) begin
				case (mode)
					0: rgb_ready <= 1'b1;
					1: rgb_ready <= 1'($urandom_range(0, 1));
					2: rgb_ready <= ($urandom_range(0, 3) != 0);
					default: rgb_ready <= (k % 3 == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Hard stop: count cycles and fail if the run never finishes
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int i;
		hsvrgb_pkg::hsv_t x;
		hsvrgb_pkg::rgb_t want;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; rows without a known answer use the predictor
		for (i = 0; i < N_DIRECTED; i++) begin
			x.hue_degrees        = DIRECTED[i].hue;
			x.saturation_percent = DIRECTED[i].sat;
			want = DIRECTED[i].known ? DIRECTED[i].want : predict_rgb(x);
			offer(x, want);
			pace();
		end
		drain_results();

		// Random part; pause halfway until the pipeline is empty
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			x = random_hsv();
			offer(x, predict_rgb(x));
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			else
				pace();
		end

		drain_results();
		repeat (LATENCY + 4) @(posedge clk);

		$display("Covered %0d transfers (%0d checked): %0d wrapped hues, %0d clamped",
			n_sent, n_checked, n_wrapped, n_clamped);
		$display("saturations, %0d white inputs, with bursty input and stalled output.",
			n_white);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
design/hsvrgb_pkg.sv
design/hsv_to_rgb_full_value.sv
tb/tb_top.sv
